FILE: design/pl11_pkg.sv
package pl11_pkg;

  localparam int unsigned ValueW = 41;
  localparam int unsigned OutW   = 42;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ExpW   = 5;
  localparam int unsigned MantW  = 11;

  // Flipping the exponent sign bit maps E in -16..15 onto a shift of 0..31.
  localparam logic [ExpW-1:0] EXP_FLIP = 5'h10;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             error;
  } enc_result_t;

endpackage

FILE: design/pmbus_linear11_codec_unit.sv
// LINEAR11 codec: encode turns a positive Q16 value into a PMBus LINEAR11 word
// (5-bit exponent, 11-bit mantissa, smallest exponent that fits with half-up
// rounding), decode expands a word into an exact Q16 value. One command is
// taken every cycle and busy is always low; the result appears with strobe once
// it has passed the input register and the result register, which lie around a
// single pass of priority encoder, shifter and rounding adder. The strobe is
// a one-cycle pulse and the receiver cannot stall it, so every result must be
// taken in the cycle it is shown. Zero or negative encode input returns word 0
// with error set.
module pmbus_linear11_codec_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic signed [pl11_pkg::ValueW-1:0]  value_q16,
  input  logic [pl11_pkg::WordW-1:0]          word_in,
  output logic                                strobe,
  output logic [pl11_pkg::WordW-1:0]          word_out,
  output logic signed [pl11_pkg::OutW-1:0]    value_out_q16,
  output logic                                error
);
  import pl11_pkg::*;

  logic                     in_vld;
  op_t                      in_op;
  logic signed [ValueW-1:0] in_value;
  logic [WordW-1:0]         in_word;

  enc_result_t              enc;
  logic [ExpW-1:0]          dec_shift;
  logic signed [OutW-1:0]   dec_mant;
  logic signed [OutW-1:0]   dec_value;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op    <= op_t'(operation);
      in_value <= value_q16;
      in_word  <= word_in;
    end
  end

  pl11_encode u_encode (
    .value  (in_value),
    .result (enc)
  );

  assign dec_shift = in_word[WordW-1:MantW] ^ EXP_FLIP;
  assign dec_mant  = OutW'($signed(in_word[MantW-1:0]));
  assign dec_value = dec_mant <<< dec_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld) begin
      unique case (in_op)
        OP_ENCODE: begin
          word_out      <= enc.word;
          value_out_q16 <= '0;
          error         <= enc.error;
        end
        OP_DECODE: begin
          word_out      <= '0;
          value_out_q16 <= dec_value;
          error         <= 1'b0;
        end
        default: begin
          word_out      <= '0;
          value_out_q16 <= '0;
          error         <= 1'b0;
        end
      endcase
    end
  end

  a_strobe_follows: assert property (@(posedge clk) disable iff (rst)
    in_vld |=> strobe)
    else $error("accepted beat did not produce a result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !in_vld |=> !strobe)
    else $error("result strobe without an accepted beat");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && error) |-> (word_out == '0 && value_out_q16 == '0))
    else $error("error result carries nonzero payload");

  a_decode_clean: assert property (@(posedge clk) disable iff (rst)
    (in_vld && in_op == OP_DECODE) |=> (!error && word_out == '0))
    else $error("decode result has error or word set");

  a_encode_mant: assert property (@(posedge clk) disable iff (rst)
    (in_vld && in_op == OP_ENCODE) |=> (word_out[MantW-1] == 1'b0 && value_out_q16 == '0))
    else $error("encode mantissa out of range or value nonzero");

endmodule

FILE: design/pl11_encode.sv
module pl11_encode (
  input  logic signed [pl11_pkg::ValueW-1:0] value,
  output pl11_pkg::enc_result_t              result
);
  import pl11_pkg::*;

  logic [ValueW-1:0]  v;
  logic               fits_direct;
  logic [5:0]         msb;
  logic [4:0]         sh;
  logic [4:0]         sh_m1;
  logic [ValueW-1:0]  shifted;
  logic [MantW-1:0]   rounded;
  logic [4:0]         s_final;
  logic [9:0]         mant;

  assign v           = value;
  assign fits_direct = (v[ValueW-2:10] == '0);

  always_comb begin
    msb = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (v[i]) begin
        msb = 6'(i);
      end
    end
  end

  // For a large value the shift that leaves 10 significant bits is msb - 9.
  // Rounding can carry up to 1024; then one more shift gives exactly 512.
  assign sh      = fits_direct ? 5'd0 : 5'(msb - 6'd9);
  assign sh_m1   = sh - 5'd1;
  assign shifted = v >> sh_m1;
  assign rounded = {1'b0, shifted[10:1]} + {10'd0, shifted[0]};

  always_comb begin
    if (fits_direct) begin
      s_final = 5'd0;
      mant    = v[9:0];
    end else if (rounded[10]) begin
      s_final = sh + 5'd1;
      mant    = 10'd512;
    end else begin
      s_final = sh;
      mant    = rounded[9:0];
    end
  end

  always_comb begin
    result.error = v[ValueW-1] || (v == '0);
    if (result.error) begin
      result.word = '0;
    end else begin
      result.word = {s_final ^ EXP_FLIP, 1'b0, mant};
    end
  end

endmodule
